FILE: hdl/hierarchical_bitmap_allocator_macros.svh
// ----------------------------------------------------------------------------
// hierarchical bitmap allocator assertion macros
// clocked implication checks used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef HIERARCHICAL_BITMAP_ALLOCATOR_MACROS_SVH
`define HIERARCHICAL_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define HBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/hba_pkg.sv
// ----------------------------------------------------------------------------
// hba_pkg
// shared types and constants of the hierarchical bitmap allocator
// ----------------------------------------------------------------------------
package hba_pkg;

    localparam int unsigned ID_W       = 18;
    localparam int unsigned DIGIT_W    = 6;
    localparam int unsigned FAN        = 64;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned MAX_LEVELS = 4;

    // first word address of each tree level in the unified word memory
    localparam int unsigned LEVEL_BASE [MAX_LEVELS] = '{0, 1, 65, 4161};

    typedef logic [ID_W-1:0]    t_id;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [DIGIT_W-1:0] t_digit;

    localparam t_id NO_ID = '1;

    typedef enum logic [1:0] {
        ACT_ALLOC_FIRST = 2'd0,
        ACT_ALLOC_ID    = 2'd1,
        ACT_FREE        = 2'd2,
        ACT_QUERY       = 2'd3
    } t_action;

    typedef struct packed {
        logic valid;
        logic ok;
        t_id  id;
    } t_walk_res;

endpackage

FILE: hdl/hba_mem.sv
// ----------------------------------------------------------------------------
// hba_mem
// bitmap word memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module hba_mem
    import hba_pkg::*;
#(
    parameter int unsigned DEPTH  = 4161,
    parameter int unsigned ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_word             i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_word             o_rd_data
);

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/hba_walk.sv
// ----------------------------------------------------------------------------
// hba_walk
// tree walk sequencer: reads one word per level down the path, decides,
// then, unless it is a query or a rejected action, writes the modified words back up the path
// ----------------------------------------------------------------------------
module hba_walk
    import hba_pkg::*;
#(
    parameter int unsigned LEVELS   = 3,
    parameter int unsigned SEGMENTS = 262144,
    parameter int unsigned ADDR_W   = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_action           i_action,
    input  t_id               i_segment_id,
    input  logic              i_take,
    output t_walk_res         o_res,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  t_word             i_rd_data,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output t_word             o_wr_data
);

    localparam int unsigned LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int unsigned PATH_W = DIGIT_W * LEVELS;
    localparam logic [LVL_W-1:0] LAST_LVL  = LVL_W'(LEVELS - 1);
    localparam logic [31:0]      SEG_LIMIT = 32'(SEGMENTS);

    typedef enum logic [1:0] {S_IDLE, S_DESC, S_ASC, S_DONE} t_state;

    t_state             r_state, n_state;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    t_action            r_action, n_action;
    t_id                r_id, n_id;
    t_digit             r_digit [LEVELS];
    t_digit             n_digit [LEVELS];
    t_word              r_word [LEVELS];
    t_word              n_word [LEVELS];
    logic               r_root_zero, n_root_zero;
    logic               r_full, n_full;
    logic               r_set, n_set;
    logic               r_ok, n_ok;
    t_id                r_res_id, n_res_id;

    t_digit             cur_digit [LEVELS];
    t_digit             digit_now;
    logic               leaf_bit;
    logic               root_zero_now;
    logic [PATH_W-1:0]  found;
    logic [PATH_W-1:0]  in_path;
    t_word              bit_mask;
    t_word              new_word;

    function automatic t_digit lowest_set(input t_word w);
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
        logic [7:0] sel_byte;
        byte_sel = '0;
        for (int i = 7; i >= 0; i--) begin
            if (w[8*i +: 8] != '0) begin
                byte_sel = 3'(i);
            end
        end
        sel_byte = w[8*byte_sel +: 8];
        bit_sel = '0;
        for (int i = 7; i >= 0; i--) begin
            if (sel_byte[i]) begin
                bit_sel = 3'(i);
            end
        end
        return {byte_sel, bit_sel};
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                  input t_digit dig [LEVELS]);
        logic [PATH_W-1:0] row;
        row = '0;
        for (int j = 0; j < LEVELS; j++) begin
            if (j < int'(lvl)) begin
                row[DIGIT_W*j +: DIGIT_W] = dig[j];
            end
        end
        return ADDR_W'(LEVEL_BASE[2'(lvl)] + 32'(row));
    endfunction

    assign in_path = PATH_W'(i_segment_id);

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_action    = r_action;
        n_id        = r_id;
        n_digit     = r_digit;
        n_word      = r_word;
        n_root_zero = r_root_zero;
        n_full      = r_full;
        n_set       = r_set;
        n_ok        = r_ok;
        n_res_id    = r_res_id;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = '0;
        o_wr_data   = '0;

        digit_now = (r_action == ACT_ALLOC_FIRST) ? lowest_set(i_rd_data) : r_digit[r_lvl];
        cur_digit = r_digit;
        cur_digit[r_lvl] = digit_now;
        leaf_bit      = i_rd_data[digit_now];
        root_zero_now = (r_lvl == '0) ? (i_rd_data == '0) : r_root_zero;
        found = '0;
        for (int d = 0; d < LEVELS; d++) begin
            found[DIGIT_W*(LEVELS-1-d) +: DIGIT_W] = cur_digit[d];
        end
        bit_mask = t_word'(1) << r_digit[r_lvl];
        if (r_set) begin
            new_word = r_word[r_lvl] | bit_mask;
        end else if (r_full) begin
            new_word = r_word[r_lvl] & ~bit_mask;
        end else begin
            new_word = r_word[r_lvl];
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_action = i_action;
                    n_id     = i_segment_id;
                    for (int d = 0; d < LEVELS; d++) begin
                        n_digit[d] = in_path[DIGIT_W*(LEVELS-1-d) +: DIGIT_W];
                    end
                    n_lvl     = '0;
                    o_rd_en   = 1'b1;
                    o_rd_addr = addr_of(LVL_W'(0), n_digit);
                    n_state   = S_DESC;
                end
            end
            S_DESC: begin
                n_word[r_lvl]  = i_rd_data;
                n_digit[r_lvl] = digit_now;
                n_root_zero    = root_zero_now;
                if (r_lvl != LAST_LVL) begin
                    n_lvl     = LVL_W'(r_lvl + 1'b1);
                    o_rd_en   = 1'b1;
                    o_rd_addr = addr_of(LVL_W'(r_lvl + 1'b1), cur_digit);
                end else begin
                    n_full   = 1'b1;
                    n_set    = 1'b0;
                    n_state  = S_DONE;
                    n_res_id = r_id;
                    unique case (r_action)
                        ACT_ALLOC_FIRST: begin
                            n_res_id = NO_ID;
                            n_ok     = 1'b0;
                            if (!root_zero_now && (32'(found) < SEG_LIMIT)) begin
                                n_res_id = ID_W'(found);
                                n_ok     = 1'b1;
                                n_state  = S_ASC;
                            end
                        end
                        ACT_ALLOC_ID: begin
                            n_ok = 1'b1;
                            if (32'(r_id) < SEG_LIMIT) begin
                                n_state = S_ASC;
                            end
                        end
                        ACT_FREE: begin
                            n_ok  = !leaf_bit;
                            n_set = 1'b1;
                            if (!leaf_bit) begin
                                n_state = S_ASC;
                            end
                        end
                        ACT_QUERY: begin
                            n_ok = leaf_bit;
                        end
                    endcase
                end
            end
            S_ASC: begin
                o_wr_en   = 1'b1;
                o_wr_addr = addr_of(r_lvl, r_digit);
                o_wr_data = new_word;
                n_full    = (new_word == '0);
                if (r_lvl == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_lvl = LVL_W'(r_lvl - 1'b1);
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_id        <= n_id;
        r_digit     <= n_digit;
        r_word      <= n_word;
        r_root_zero <= n_root_zero;
        r_full      <= n_full;
        r_set       <= n_set;
        r_ok        <= n_ok;
        r_res_id    <= n_res_id;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
    end

    assign o_res.valid = (r_state == S_DONE);
    assign o_res.ok    = r_ok;
    assign o_res.id    = r_res_id;

endmodule

FILE: hdl/hierarchical_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_allocator
// segment id allocator over a 64-way bitmap tree held in one word memory
//
// channel   direction  handshake          fields
// input     in         i_valid / o_stall  i_action, i_segment_id
// output    out        o_valid / i_stall  o_result_id, o_ok
//
// an item walks LEVELS memory reads down and, when it changes the tree,
// LEVELS writes back up; a query or a rejected action only does the reads;
// one item is walked at a time, the next is accepted once its result is taken
// after reset the word memory is filled with ones, one word a cycle,
// all (64**LEVELS-1)/63 words (4161 at LEVELS = 3), with o_stall high
// one result waits in the output register; the next item is taken meanwhile
// ----------------------------------------------------------------------------
`include "hierarchical_bitmap_allocator_macros.svh"

module hierarchical_bitmap_allocator
    import hba_pkg::*;
#(
    parameter int unsigned LEVELS   = 3,
    parameter int unsigned SEGMENTS = 262144
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [1:0]      i_action,
    input  logic [ID_W-1:0] i_segment_id,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [ID_W-1:0] o_result_id,
    output logic            o_ok
);

    localparam int unsigned WORDS  = ((FAN ** LEVELS) - 1) / (FAN - 1);
    localparam int unsigned ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

    logic              r_clr_busy, n_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_busy, n_busy;
    logic              r_out_valid, n_out_valid;
    t_id               r_out_id, n_out_id;
    logic              r_out_ok, n_out_ok;

    logic              accept;
    logic              take;
    t_walk_res         walk_res;
    logic              walk_rd_en;
    logic [ADDR_W-1:0] walk_rd_addr;
    logic              walk_wr_en;
    logic [ADDR_W-1:0] walk_wr_addr;
    t_word             walk_wr_data;
    t_word             rd_data;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    t_word             mem_wr_data;

    assign o_stall = r_clr_busy || r_busy;
    assign accept  = i_valid && !o_stall;
    assign take    = walk_res.valid && (!r_out_valid || !i_stall);

    // reset fill shares the write port
    assign mem_wr_en   = r_clr_busy || walk_wr_en;
    assign mem_wr_addr = r_clr_busy ? r_clr_addr : walk_wr_addr;
    assign mem_wr_data = r_clr_busy ? '1 : walk_wr_data;

    hba_mem #(
        .DEPTH  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (walk_rd_en),
        .i_rd_addr (walk_rd_addr),
        .o_rd_data (rd_data)
    );

    hba_walk #(
        .LEVELS   (LEVELS),
        .SEGMENTS (SEGMENTS),
        .ADDR_W   (ADDR_W)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept),
        .i_action     (t_action'(i_action)),
        .i_segment_id (i_segment_id),
        .i_take       (take),
        .o_res        (walk_res),
        .o_rd_en      (walk_rd_en),
        .o_rd_addr    (walk_rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (walk_wr_en),
        .o_wr_addr    (walk_wr_addr),
        .o_wr_data    (walk_wr_data)
    );

    always_comb begin
        n_clr_busy  = r_clr_busy;
        n_clr_addr  = r_clr_addr;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        n_out_id    = r_out_id;
        n_out_ok    = r_out_ok;
        if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                n_clr_busy = 1'b0;
            end else begin
                n_clr_addr = ADDR_W'(r_clr_addr + 1'b1);
            end
        end
        if (accept) begin
            n_busy = 1'b1;
        end else if (take) begin
            n_busy = 1'b0;
        end
        if (take) begin
            n_out_valid = 1'b1;
            n_out_id    = walk_res.id;
            n_out_ok    = walk_res.ok;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_id <= n_out_id;
        r_out_ok <= n_out_ok;
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_busy  <= n_clr_busy;
            r_clr_addr  <= n_clr_addr;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_result_id = r_out_id;
    assign o_ok        = r_out_ok;

    `HBA_ASSERT_NOW(a_clr_no_walk, i_clk, i_rst_n, r_clr_busy, !walk_wr_en && !walk_rd_en, "walk memory access during fill")
    `HBA_ASSERT_NOW(a_res_busy, i_clk, i_rst_n, walk_res.valid, r_busy, "walk result without an item in flight")
    `HBA_ASSERT_NOW(a_one_access, i_clk, i_rst_n, walk_wr_en, !walk_rd_en, "walk reads and writes in one cycle")
    `HBA_ASSERT_NEXT(a_take_loads, i_clk, i_rst_n, take, o_valid && (o_result_id == $past(walk_res.id)), "result not loaded")

endmodule
